// ===== hdl/nrcr_pkg.sv =====
`default_nettype none
package nrcr_pkg;

  // wide widths: |f| stays below 2^95 and |f'| below 2^64 for any 32-bit estimate
  localparam int NUM_W = 96;
  localparam int DEN_W = 66;

  localparam logic [1:0] OUTCOME_CONVERGED = 2'd0;
  localparam logic [1:0] OUTCOME_DERIV_ZERO = 2'd1;
  localparam logic [1:0] OUTCOME_LIMIT = 2'd2;

  localparam logic CFG_STEP_TOLERANCE = 1'b0;
  localparam logic CFG_ITERATION_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_CL,
    OP_CH,
    OP_F1,
    OP_F2,
    OP_F3,
    OP_F4,
    OP_DIVS,
    OP_Q0,
    OP_U1,
    OP_U2,
    OP_U3,
    OP_U4,
    OP_PUSH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       fin;
    logic [1:0] outcome;
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic dzero;
    logic conv;
    logic div_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/nrcr_div.sv =====
`default_nettype none
module nrcr_div #(
  parameter int NW = 96,
  parameter int DW = 66
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               busy_o,
  output logic [NW-1:0]      quot_o
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic [DW:0]   rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_sh;
  logic          take;

  // restoring divide, one quotient bit a cycle; numerator shifts out as quotient shifts in
  assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
  assign take   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[NW-2:0], take};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

// ===== hdl/nrcr_dp.sv =====
`default_nettype none
module nrcr_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire nrcr_pkg::cmd_t  cmd_i,
  output nrcr_pkg::sts_t       sts_o,
  input  wire logic            cfg_valid_i,
  input  wire logic            cfg_index_i,
  input  wire logic [31:0]     cfg_data_i,
  input  wire logic [31:0]     start_guess_i,
  output logic [31:0]          root_estimate_o,
  output logic [31:0]          residual_o,
  output logic [1:0]           outcome_o,
  output logic [7:0]           iterations_used_o
);
  import nrcr_pkg::*;

  localparam logic signed [DEN_W-1:0] DLIM = DEN_W'(1) << FRAC_BITS;
  localparam logic [DEN_W-1:0] ONE_D = DEN_W'(1) << (2 * FRAC_BITS);
  localparam logic [NUM_W-1:0] TWO_N = NUM_W'(2) << (3 * FRAC_BITS);

  logic [30:0] tol_q;
  logic [7:0]  lim_q;

  logic signed [31:0]      x_q, x1_q;
  logic [7:0]              it_q;
  logic [63:0]             sq_q, cl_q, ch_q;
  logic [NUM_W-1:0]        cube_q;
  logic signed [NUM_W-1:0] n_q, qs_q;
  logic signed [DEN_W-1:0] d_q;
  logic signed [NUM_W:0]   w_q;
  logic signed [32:0]      diff_q;
  logic signed [31:0]      res_q;
  logic                    sign_q;

  logic [32:0]      negx, mag;
  logic [31:0]      ax, mul_b;
  logic [63:0]      prod;
  logic [NUM_W-1:0] nmag, quot, qmag;
  logic [DEN_W-1:0] dmag;
  logic             div_start, div_busy;

  function automatic logic [31:0] sat32(input logic signed [NUM_W:0] w);
    if ((&w[NUM_W:31]) || !(|w[NUM_W:31])) begin
      return w[31:0];
    end
    return w[NUM_W] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 31'd66;
      lim_q <= 8'd50;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP_TOLERANCE:  tol_q <= cfg_data_i[30:0];
        CFG_ITERATION_LIMIT: lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign negx = 33'(0) - {x_q[31], x_q};
  assign ax   = x_q[31] ? negx[31:0] : x_q;

  always_comb begin
    case (cmd_i.op)
      OP_CL:   mul_b = sq_q[31:0];
      OP_CH:   mul_b = sq_q[63:32];
      default: mul_b = ax;
    endcase
  end
  assign prod = ax * mul_b;

  assign nmag = n_q[NUM_W-1] ? (NUM_W'(0) - n_q) : n_q;
  assign dmag = d_q[DEN_W-1] ? (DEN_W'(0) - d_q) : d_q;
  assign div_start = (cmd_i.op == OP_DIVS) && !cmd_i.fin;

  // residual divides by a power of two: shift the magnitude
  assign qmag = cmd_i.fin ? (nmag >> (2 * FRAC_BITS)) : quot;

  nrcr_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (nmag),
    .den_i   (dmag),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q  <= start_guess_i;
        it_q <= '0;
      end
      OP_SQ: sq_q <= prod;
      OP_CL: cl_q <= prod;
      OP_CH: ch_q <= prod;
      OP_F1: begin
        cube_q <= (NUM_W'(ch_q) << 32) + NUM_W'(cl_q);
        d_q    <= DEN_W'(sq_q) + (DEN_W'(sq_q) << 1);
      end
      OP_F2: begin
        n_q <= x_q[31] ? (NUM_W'(0) - cube_q) : cube_q;
        d_q <= d_q - ONE_D;
      end
      OP_F3: n_q <= n_q - ({{(NUM_W-32){x_q[31]}}, x_q} <<< (2 * FRAC_BITS));
      OP_F4: n_q <= n_q - TWO_N;
      OP_DIVS: sign_q <= n_q[NUM_W-1] ^ (!cmd_i.fin && d_q[DEN_W-1]);
      OP_Q0: qs_q <= sign_q ? (NUM_W'(0) - qmag) : qmag;
      OP_U1: begin
        if (cmd_i.fin) begin
          w_q <= {qs_q[NUM_W-1], qs_q};
        end else begin
          w_q <= {{(NUM_W-31){x_q[31]}}, x_q} - {qs_q[NUM_W-1], qs_q};
        end
      end
      OP_U2: begin
        if (cmd_i.fin) begin
          res_q <= sat32(w_q);
        end else begin
          x1_q <= sat32(w_q);
        end
      end
      OP_U3: diff_q <= {x1_q[31], x1_q} - {x_q[31], x_q};
      OP_U4: begin
        x_q  <= x1_q;
        it_q <= it_q + 8'd1;
      end
      OP_PUSH: begin
        root_estimate_o   <= x_q;
        residual_o        <= res_q;
        outcome_o         <= cmd_i.outcome;
        iterations_used_o <= it_q;
      end
      default: ;
    endcase
  end

  assign mag = diff_q[32] ? (33'(0) - diff_q) : diff_q;

  assign sts_o.at_limit = it_q == lim_q;
  assign sts_o.dzero    = (d_q < DLIM) && (d_q > -DLIM);
  assign sts_o.conv     = mag < {2'b00, tol_q};
  assign sts_o.div_busy = div_busy;
endmodule
`default_nettype wire

// ===== hdl/nrcr_ctrl.sv =====
`default_nettype none
module nrcr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire nrcr_pkg::sts_t sts_i,
  output nrcr_pkg::cmd_t      cmd_o
);
  import nrcr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_SQ, S_CL, S_CH, S_F1, S_F2, S_F3, S_F4,
    S_DIVS, S_DIVW, S_Q0, S_U1, S_U2, S_U3, S_U4, S_PUSH
  } state_e;

  state_e     state_q;
  logic       fin_q;
  logic [1:0] oc_q;
  logic       out_valid_q;
  logic       push_ok;

  assign push_ok = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.fin     = fin_q;
    cmd_o.outcome = oc_q;
    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_SQ:    cmd_o.op = OP_SQ;
      S_CL:    cmd_o.op = OP_CL;
      S_CH:    cmd_o.op = OP_CH;
      S_F1:    cmd_o.op = OP_F1;
      S_F2:    cmd_o.op = OP_F2;
      S_F3:    cmd_o.op = OP_F3;
      S_F4:    cmd_o.op = OP_F4;
      S_DIVS:  cmd_o.op = OP_DIVS;
      S_Q0:    cmd_o.op = OP_Q0;
      S_U1:    cmd_o.op = OP_U1;
      S_U2:    cmd_o.op = OP_U2;
      S_U3:    cmd_o.op = OP_U3;
      S_U4:    cmd_o.op = OP_U4;
      S_PUSH:  cmd_o.op = push_ok ? OP_PUSH : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      oc_q        <= OUTCOME_LIMIT;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            fin_q   <= 1'b0;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (sts_i.at_limit) begin
            fin_q <= 1'b1;
            oc_q  <= OUTCOME_LIMIT;
          end
          state_q <= S_SQ;
        end
        S_SQ: state_q <= S_CL;
        S_CL: state_q <= S_CH;
        S_CH: state_q <= S_F1;
        S_F1: state_q <= S_F2;
        S_F2: state_q <= S_F3;
        S_F3: state_q <= S_F4;
        S_F4: begin
          // flat derivative: drop the step and finish on the current estimate
          if (!fin_q && sts_i.dzero) begin
            fin_q   <= 1'b1;
            oc_q    <= OUTCOME_DERIV_ZERO;
            state_q <= S_SQ;
          end else begin
            state_q <= S_DIVS;
          end
        end
        // the residual needs only a shift, so skip the divider wait
        S_DIVS: state_q <= fin_q ? S_Q0 : S_DIVW;
        S_DIVW: if (!sts_i.div_busy) state_q <= S_Q0;
        S_Q0:   state_q <= S_U1;
        S_U1:   state_q <= S_U2;
        S_U2:   state_q <= fin_q ? S_PUSH : S_U3;
        S_U3:   state_q <= S_U4;
        S_U4: begin
          if (sts_i.conv) begin
            fin_q   <= 1'b1;
            oc_q    <= OUTCOME_CONVERGED;
            state_q <= S_SQ;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_PUSH: begin
          // hold until the output register is free
          if (push_ok) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

// ===== hdl/newton_raphson_cubic_root.sv =====
// channel | direction | handshake           | payload
// cfg     | in        | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i/ready_o  | start_guess_i
// out     | out       | out_valid_o/ready_i | root_estimate_o, residual_o, outcome_o,
//         |           |                     | iterations_used_o
// Each iteration checks the limit, squares and cubes the estimate on the multiplier,
// forms f and f', divides and updates; a final pass forms the residual with a shift.
// The 96-bit bit-serial divider sets most of an iteration, the shared 32x32
// multiplier the rest. Reset restores tolerance 66 and limit 50. A finished word
// waits in the output register while the next word is accepted; the block holds
// before writing a new result until that register is taken.
`default_nettype none
module newton_raphson_cubic_root #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] start_guess_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      root_estimate_o,
  output logic [31:0]      residual_o,
  output logic [1:0]       outcome_o,
  output logic [7:0]       iterations_used_o
);
  import nrcr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  nrcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nrcr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .start_guess_i     (start_guess_i),
    .root_estimate_o   (root_estimate_o),
    .residual_o        (residual_o),
    .outcome_o         (outcome_o),
    .iterations_used_o (iterations_used_o)
  );
endmodule
`default_nettype wire

// ===== hdl/nrcr_checker.sv =====
`default_nettype none
module nrcr_props (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [31:0] root_estimate_o,
  input wire logic [1:0] outcome_o,
  input wire logic [7:0] iterations_used_o
);
  import nrcr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_estimate_o))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outcome_o == OUTCOME_CONVERGED || outcome_o == OUTCOME_DERIV_ZERO
                    || outcome_o == OUTCOME_LIMIT)
    else $error("bad outcome code");

  a_conv_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OUTCOME_CONVERGED |-> iterations_used_o != 8'd0)
    else $error("converged with no iteration");
endmodule

bind newton_raphson_cubic_root nrcr_props u_nrcr_props (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .root_estimate_o   (root_estimate_o),
  .outcome_o         (outcome_o),
  .iterations_used_o (iterations_used_o)
);
`default_nettype wire

// ===== test/nrcr_checker.sv =====
`timescale 1ns / 1ps
module nrcr_checker
  import nrcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] start_guess_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] root_estimate_i,
  input  logic [31:0] residual_i,
  input  logic [1:0]  outcome_i,
  input  logic [7:0]  iterations_used_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [31:0] root;
    logic [31:0] resid;
    logic [1:0]  outcome;
    logic [7:0]  used;
  } root_result_t;

  logic [30:0] tolerance_q;
  logic [7:0]  limit_q;
  root_result_t roots_q[$];

  function automatic wide_t cubic_at(wide_t x);
    return x * x * x - (x <<< 32) - (wide_t'(2) <<< 48);
  endfunction

  function automatic wide_t slope_at(wide_t x);
    return 3 * x * x - (wide_t'(1) <<< 32);
  endfunction

  function automatic wide_t mag(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic wide_t clamp32(wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return wide_t'(32'sh7fffffff);
    if (v < wide_t'(-33'sh080000000)) return wide_t'(-33'sh080000000);
    return v;
  endfunction

  function automatic root_result_t solve_root(logic signed [31:0] guess);
    wide_t x, fx, dx, x1, diff;
    root_result_t r;
    int i;
    x = wide_t'(guess);
    r.outcome = OUTCOME_LIMIT;
    r.used = limit_q;
    for (i = 1; i <= int'(limit_q); i++) begin
      fx = cubic_at(x);
      dx = slope_at(x);
      if (mag(dx) < (wide_t'(1) <<< 16)) begin
        r.outcome = OUTCOME_DERIV_ZERO;
        r.used = 8'(i - 1);
        break;
      end
      x1 = clamp32(x - fx / dx);
      diff = x1 - x;
      x = x1;
      if (mag(diff) < wide_t'({1'b0, tolerance_q})) begin
        r.outcome = OUTCOME_CONVERGED;
        r.used = 8'(i);
        break;
      end
    end
    r.root = x[31:0];
    r.resid = 32'(clamp32(cubic_at(x) / (wide_t'(1) <<< 32)));
    return r;
  endfunction

  assign pending_o = roots_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    root_result_t exp_r;
    if (!rst_ni) begin
      tolerance_q <= 31'd66;
      limit_q <= 8'd50;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_STEP_TOLERANCE) tolerance_q <= cfg_data_i[30:0];
        else limit_q <= cfg_data_i[7:0];
      end
      if (in_valid_i && in_ready_i) roots_q.push_back(solve_root(start_guess_i));
      if (out_valid_i && out_ready_i) begin
        if (roots_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = roots_q.pop_front();
          if (exp_r.root !== root_estimate_i ||
              exp_r.resid !== residual_i ||
              exp_r.outcome !== outcome_i ||
              exp_r.used !== iterations_used_i)
            fail_count_o <= fail_count_o + 1;
          if (exp_r.root !== root_estimate_i)
            $error("root_estimate expected %h got %h", exp_r.root, root_estimate_i);
          if (exp_r.resid !== residual_i)
            $error("residual expected %h got %h", exp_r.resid, residual_i);
          if (exp_r.outcome !== outcome_i)
            $error("outcome expected %0d got %0d", exp_r.outcome, outcome_i);
          if (exp_r.used !== iterations_used_i)
            $error("iterations_used expected %0d got %0d", exp_r.used,
                   iterations_used_i);
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import nrcr_pkg::*;

  localparam longint CYCLE_LIMIT = 40000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] start_guess_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] root_estimate_o;
  logic [31:0] residual_o;
  logic [1:0]  outcome_o;
  logic [7:0]  iterations_used_o;
  int          fail_count;
  int          pending;
  longint      cycles = 0;
  bit          jitter = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  newton_raphson_cubic_root i_dut (.*);

  nrcr_checker i_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .start_guess_i,
    .out_valid_i(out_valid_o), .out_ready_i, .root_estimate_i(root_estimate_o),
    .residual_i(residual_o), .outcome_i(outcome_o),
    .iterations_used_i(iterations_used_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stall the result side per word
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = jitter ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_guess(logic [31:0] g);
    int gap;
    gap = jitter ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_guess_i <= g;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    // let the checker record the last accepted word first
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_guess();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    if (pick < 85) return $urandom();
    // near the flat spots of the slope
    if (pick < 92) return 32'(37837 + int'($urandom_range(0, 8)) - 4);
    return 32'(-37837 + int'($urandom_range(0, 8)) - 4);
  endfunction

  task automatic random_run(int count, bit hold_mid);
    for (int k = 0; k < count; k++) begin
      send_guess(random_guess());
      // wait for every result once mid phase
      if (hold_mid && k == count / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'h0001_0000, 32'hffff_0000, 32'h0001_8000,
                 32'h0001_5000, 32'h0000_93cd, 32'hffff_6c33, 32'h0000_93ce,
                 32'hffff_6c32, 32'h5555_5555, 32'haaaa_aaaa, 32'h0002_0000};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    foreach (directed[k]) send_guess(directed[k]);
    drain();

    // tightest tolerance, long limit, few words
    write_reg(CFG_STEP_TOLERANCE, 32'h0000_0001);
    write_reg(CFG_ITERATION_LIMIT, 32'h0000_00ff);
    for (int k = 0; k < 6; k++) send_guess(directed[k]);
    drain();

    // widest tolerance, single iteration
    write_reg(CFG_STEP_TOLERANCE, 32'h7fff_ffff);
    write_reg(CFG_ITERATION_LIMIT, 32'h0000_0001);
    random_run(60, 1'b0);

    // zero limit and zero tolerance
    write_reg(CFG_ITERATION_LIMIT, 32'hffff_ff00);
    for (int k = 0; k < 5; k++) send_guess(directed[k]);
    drain();
    write_reg(CFG_STEP_TOLERANCE, 32'h8000_0000);
    write_reg(CFG_ITERATION_LIMIT, 32'd12);
    random_run(20, 1'b0);

    // back to reset values, no idling, hold once for an empty pipe
    jitter = 1'b0;
    write_reg(CFG_STEP_TOLERANCE, 32'd66);
    write_reg(CFG_ITERATION_LIMIT, 32'd50);
    random_run(200, 1'b1);
    jitter = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_STEP_TOLERANCE, ($urandom_range(0, 3) == 0) ? $urandom() :
                32'($urandom_range(1, 4000)));
      write_reg(CFG_ITERATION_LIMIT, {24'($urandom_range(0, 16777215)),
                                      8'($urandom_range(1, 50))});
      random_run(100, ph == 3);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
